>>> sv/mer_pkg.sv
// shared definitions for the midpoint ellipse rasterizer
// default widths, queue depth and the request kind code; no dependencies
`default_nettype none

package mer_pkg;

    // default field widths
    localparam int DEF_COORD_BITS  = 12;
    localparam int DEF_RADIUS_BITS = 10;

    // width of the emitted coordinates, fixed by the result format
    localparam int OUT_BITS = 13;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request kind as classified by the front
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_kind_t;

endpackage

`default_nettype wire

>>> sv/mer_front.sv
// front of the ellipse rasterizer: accepts requests, classifies them and squares the radii
// uses mer_pkg; feeds mer_queue
`default_nettype none

module mer_front #(
    parameter int COORD_BITS  = mer_pkg::DEF_COORD_BITS,
    parameter int RADIUS_BITS = mer_pkg::DEF_RADIUS_BITS,
    parameter int ENT_W       = 1 + 2 * COORD_BITS + 5 * RADIUS_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire logic                   op,
    input  wire logic [COORD_BITS-1:0]  center_x,
    input  wire logic [COORD_BITS-1:0]  center_y,
    input  wire logic [RADIUS_BITS-1:0] radius_x,
    input  wire logic [RADIUS_BITS-1:0] radius_y,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output logic [ENT_W-1:0]            push_data
);
    import mer_pkg::*;

    localparam int SQ_W = 2 * RADIUS_BITS;

    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    logic [ENT_W-1:0]       hold_data_reg;
    logic [ENT_W-1:0]       hold_data_next;
    logic                   accept;
    logic [SQ_W-1:0]        rx_wide;
    logic [SQ_W-1:0]        ry_wide;
    logic [SQ_W-1:0]        rx_sq;
    logic [SQ_W-1:0]        ry_sq;
    cmd_kind_t              kind;

    assign item_stall = hold_valid_reg && !push_ready;
    assign accept     = item_valid && !item_stall;

    // squares of the radii, needed only for a start
    assign rx_wide = {{RADIUS_BITS{1'b0}}, radius_x};
    assign ry_wide = {{RADIUS_BITS{1'b0}}, radius_y};
    assign rx_sq   = rx_wide * rx_wide;
    assign ry_sq   = ry_wide * ry_wide;
    assign kind    = op ? CMD_STEP : CMD_START;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
            hold_data_next  = {kind, center_x, center_y, radius_y, rx_sq, ry_sq};
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_data_reg <= hold_data_next;
    end

    assign push_valid = hold_valid_reg;
    assign push_data  = hold_data_reg;

endmodule

`default_nettype wire

>>> sv/mer_queue.sv
// short request queue between front and back of the ellipse rasterizer
// uses mer_pkg for the default depth
`default_nettype none

module mer_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mer_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_take,
    output logic [WIDTH-1:0]      pop_data
);
    import mer_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_take;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/mer_back.sv
// back of the ellipse rasterizer: midpoint sequencer with one shared multiplier
// and a result register; uses mer_pkg, fed by mer_queue
`default_nettype none

module mer_back #(
    parameter int COORD_BITS  = mer_pkg::DEF_COORD_BITS,
    parameter int RADIUS_BITS = mer_pkg::DEF_RADIUS_BITS,
    parameter int ENT_W       = 1 + 2 * COORD_BITS + 5 * RADIUS_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pop_valid,
    output logic                            pop_take,
    input  wire logic [ENT_W-1:0]           pop_data,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [mer_pkg::OUT_BITS-1:0]    pixel_x,
    output logic [mer_pkg::OUT_BITS-1:0]    pixel_y,
    output logic                            point_valid,
    output logic                            last_of_step,
    output logic                            arc_done
);
    import mer_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int R      = RADIUS_BITS;
    localparam int SQ_W   = 2 * R;
    localparam int SL_W   = 3 * R + 1;
    localparam int DEC_W  = 4 * R + 4;
    localparam int MA_W   = SL_W;
    localparam int MB_W   = SQ_W;
    localparam int MP_W   = MA_W + MB_W;
    localparam int PIX_W  = OUT_BITS + C + R;
    localparam logic [1:0] LAST_POINT = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SLOPE = 8'b0000_0010,
        S_R2A   = 8'b0000_0100,
        S_R2B   = 8'b0000_1000,
        S_R2C   = 8'b0001_0000,
        S_R2D   = 8'b0010_0000,
        S_R2E   = 8'b0100_0000,
        S_STEP  = 8'b1000_0000
    } bk_state_t;

    // emission phase, runs while the sequencer rests in idle
    typedef enum logic [1:0] {
        PH_WORK = 2'b01,
        PH_EMIT = 2'b10
    } bk_phase_t;

    bk_state_t               state_reg, state_next;
    bk_phase_t               phase_reg, phase_next;
    logic signed [C-1:0]     cx_reg, cx_next;
    logic signed [C-1:0]     cy_reg, cy_next;
    logic [SQ_W-1:0]         rx2_reg, rx2_next;
    logic [SQ_W-1:0]         ry2_reg, ry2_next;
    logic [R-1:0]            ox_reg, ox_next;
    logic [R-1:0]            oy_reg, oy_next;
    logic [SL_W-1:0]         sx_reg, sx_next;
    logic [SL_W-1:0]         sy_reg, sy_next;
    logic signed [DEC_W-1:0] dec_reg, dec_next;
    logic signed [DEC_W-1:0] acc_reg, acc_next;
    logic [SL_W-1:0]         tmp_reg, tmp_next;
    logic                    r2_reg, r2_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    null_reg, null_next;
    logic [1:0]              k_reg, k_next;

    logic                    rv_reg, rv_next;
    logic [OUT_BITS-1:0]     px_reg, px_next;
    logic [OUT_BITS-1:0]     py_reg, py_next;
    logic                    pv_reg, pv_next;
    logic                    last_reg, last_next;
    logic                    arc_reg, arc_next;

    cmd_kind_t               ent_kind;
    logic [C-1:0]            ent_cx;
    logic [C-1:0]            ent_cy;
    logic [R-1:0]            ent_ry;
    logic [SQ_W-1:0]         ent_rx2;
    logic [SQ_W-1:0]         ent_ry2;

    logic [MA_W-1:0]         mul_a;
    logic [MB_W-1:0]         mul_b;
    logic [MP_W-1:0]         mul_p;
    logic signed [DEC_W-1:0] prod_s;
    logic [R:0]              t_val;
    logic [R-1:0]            u_val;

    logic [SL_W-1:0]         sx_inc;
    logic [SL_W-1:0]         sy_dec;
    logic signed [DEC_W-1:0] rx2_s, ry2_s, sxi_s, syd_s;
    logic                    load_ok;
    logic signed [PIX_W-1:0] cx_w, cy_w, ox_w, oy_w, xs_w, ys_w;

    // unpack the queued request
    assign ent_kind = cmd_kind_t'(pop_data[ENT_W-1]);
    assign ent_cx   = pop_data[5*R+2*C-1 -: C];
    assign ent_cy   = pop_data[5*R+C-1 -: C];
    assign ent_ry   = pop_data[5*R-1 -: R];
    assign ent_rx2  = pop_data[4*R-1 -: SQ_W];
    assign ent_ry2  = pop_data[SQ_W-1:0];

    assign pop_take = (state_reg == S_IDLE) && (phase_reg == PH_WORK) && pop_valid;

    // midpoint helper terms
    assign t_val  = {ox_reg, 1'b1};
    assign u_val  = oy_reg - 1'b1;
    assign sx_inc = sx_reg + {{(SL_W-SQ_W-1){1'b0}}, ry2_reg, 1'b0};
    assign sy_dec = sy_reg - {{(SL_W-SQ_W-1){1'b0}}, rx2_reg, 1'b0};
    assign rx2_s  = signed'({{(DEC_W-SQ_W){1'b0}}, rx2_reg});
    assign ry2_s  = signed'({{(DEC_W-SQ_W){1'b0}}, ry2_reg});
    assign sxi_s  = signed'({{(DEC_W-SL_W){1'b0}}, sx_inc});
    assign syd_s  = signed'({{(DEC_W-SL_W){1'b0}}, sy_dec});

    // shared multiplier, operands chosen by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SLOPE:
            begin
                mul_a = {{(MA_W-SQ_W){1'b0}}, rx2_reg};
                mul_b = {{(MB_W-R){1'b0}}, oy_reg};
            end
            S_R2A:
            begin
                mul_a = {{(MA_W-SQ_W){1'b0}}, ry2_reg};
                mul_b = {{(MB_W-R-1){1'b0}}, t_val};
            end
            S_R2B:
            begin
                mul_a = tmp_reg;
                mul_b = {{(MB_W-R-1){1'b0}}, t_val};
            end
            S_R2C:
            begin
                mul_a = {{(MA_W-SQ_W){1'b0}}, rx2_reg};
                mul_b = {{(MB_W-R){1'b0}}, u_val};
            end
            S_R2D:
            begin
                mul_a = tmp_reg;
                mul_b = {{(MB_W-R){1'b0}}, u_val};
            end
            S_R2E:
            begin
                mul_a = {{(MA_W-SQ_W){1'b0}}, rx2_reg};
                mul_b = ry2_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign prod_s = signed'(mul_p[DEC_W-1:0]);

    // point coordinates for the current quadrant
    assign cx_w = PIX_W'(cx_reg);
    assign cy_w = PIX_W'(cy_reg);
    assign ox_w = signed'({{(PIX_W-R){1'b0}}, ox_reg});
    assign oy_w = signed'({{(PIX_W-R){1'b0}}, oy_reg});
    assign xs_w = k_reg[0] ? (cx_w - ox_w) : (cx_w + ox_w);
    assign ys_w = k_reg[1] ? (cy_w - oy_w) : (cy_w + oy_w);

    assign load_ok = !rv_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rx2_next   = rx2_reg;
        ry2_next   = ry2_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        dec_next   = dec_reg;
        acc_next   = acc_reg;
        tmp_next   = tmp_reg;
        r2_next    = r2_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        null_next  = null_reg;
        k_next     = k_reg;

        rv_next    = rv_reg && result_stall;
        px_next    = px_reg;
        py_next    = py_reg;
        pv_next    = pv_reg;
        last_next  = last_reg;
        arc_next   = arc_reg;

        if (phase_reg == PH_EMIT)
        begin
            if (load_ok)
            begin
                rv_next = 1'b1;
                if (null_reg)
                begin
                    px_next    = '0;
                    py_next    = '0;
                    pv_next    = 1'b0;
                    last_next  = 1'b1;
                    arc_next   = 1'b0;
                    phase_next = PH_WORK;
                end
                else
                begin
                    px_next   = xs_w[OUT_BITS-1:0];
                    py_next   = ys_w[OUT_BITS-1:0];
                    pv_next   = 1'b1;
                    last_next = (k_reg == LAST_POINT);
                    arc_next  = (k_reg == LAST_POINT) && done_reg;
                    k_next    = k_reg + 1'b1;
                    if (k_reg == LAST_POINT)
                    begin
                        phase_next = PH_WORK;
                    end
                end
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        k_next    = '0;
                        null_next = 1'b0;
                        if (ent_kind == CMD_START)
                        begin
                            cx_next    = signed'(ent_cx);
                            cy_next    = signed'(ent_cy);
                            rx2_next   = ent_rx2;
                            ry2_next   = ent_ry2;
                            ox_next    = '0;
                            oy_next    = ent_ry;
                            sx_next    = '0;
                            r2_next    = 1'b0;
                            state_next = S_SLOPE;
                        end
                        else if (!busy_reg)
                        begin
                            null_next  = 1'b1;
                            phase_next = PH_EMIT;
                        end
                        else if (!r2_reg && (sx_reg >= sy_reg))
                        begin
                            state_next = S_R2A;
                        end
                        else
                        begin
                            state_next = S_STEP;
                        end
                    end
                end
                S_SLOPE:
                begin
                    // slope_y = 2*rx2*ry, decision = 4*ry2 - 4*rx2*ry + rx2
                    sy_next    = {mul_p[SL_W-2:0], 1'b0};
                    dec_next   = (ry2_s <<< 2) - (prod_s <<< 2) + rx2_s;
                    done_next  = (oy_reg == '0);
                    busy_next  = (oy_reg != '0);
                    state_next = S_IDLE;
                    phase_next = PH_EMIT;
                end
                S_R2A:
                begin
                    tmp_next   = mul_p[SL_W-1:0];
                    state_next = S_R2B;
                end
                S_R2B:
                begin
                    acc_next   = prod_s;
                    state_next = S_R2C;
                end
                S_R2C:
                begin
                    tmp_next   = mul_p[SL_W-1:0];
                    state_next = S_R2D;
                end
                S_R2D:
                begin
                    acc_next   = acc_reg + (prod_s <<< 2);
                    state_next = S_R2E;
                end
                S_R2E:
                begin
                    dec_next   = acc_reg - (prod_s <<< 2);
                    r2_next    = 1'b1;
                    state_next = S_STEP;
                end
                S_STEP:
                begin
                    if (!r2_reg)
                    begin
                        ox_next = ox_reg + 1'b1;
                        sx_next = sx_inc;
                        if (dec_reg[DEC_W-1])
                        begin
                            dec_next = dec_reg + ((ry2_s + sxi_s) <<< 2);
                        end
                        else
                        begin
                            oy_next  = oy_reg - 1'b1;
                            sy_next  = sy_dec;
                            dec_next = dec_reg + ((ry2_s + sxi_s - syd_s) <<< 2);
                        end
                    end
                    else
                    begin
                        oy_next = oy_reg - 1'b1;
                        sy_next = sy_dec;
                        if (!dec_reg[DEC_W-1] && (dec_reg != '0))
                        begin
                            dec_next = dec_reg + ((rx2_s - syd_s) <<< 2);
                        end
                        else
                        begin
                            ox_next  = ox_reg + 1'b1;
                            sx_next  = sx_inc;
                            dec_next = dec_reg + ((rx2_s - syd_s + sxi_s) <<< 2);
                        end
                    end
                    done_next  = (oy_next == '0);
                    busy_next  = (oy_next != '0);
                    state_next = S_IDLE;
                    phase_next = PH_EMIT;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_WORK;
            r2_reg    <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            null_reg  <= 1'b0;
            k_reg     <= '0;
            rv_reg    <= 1'b0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            dec_reg   <= '0;
            rx2_reg   <= '0;
            ry2_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            r2_reg    <= r2_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            null_reg  <= null_next;
            k_reg     <= k_next;
            rv_reg    <= rv_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            dec_reg   <= dec_next;
            rx2_reg   <= rx2_next;
            ry2_reg   <= ry2_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        tmp_reg  <= tmp_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pv_reg   <= pv_next;
        last_reg <= last_next;
        arc_reg  <= arc_next;
    end

    assign result_valid = rv_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign point_valid  = pv_reg;
    assign last_of_step = last_reg;
    assign arc_done     = arc_reg;

endmodule

`default_nettype wire

>>> sv/midpoint_ellipse_rasterizer.sv
// top level of the midpoint ellipse rasterizer
// uses mer_pkg; instantiates mer_front, mer_queue and mer_back
`default_nettype none

// Axis-aligned midpoint ellipse rasterizer. A start request (op = 0) loads the
// centre and both semi-axes and yields the four mirrored points at x = 0,
// y = radius_y; each step request (op = 1) advances the arc by one pixel and
// yields four points, the fourth flagged last_of_step and, when the arc has
// reached y = 0, arc_done. A step with no arc in progress yields a single
// result with point_valid low. A start while an arc is running abandons it.
// The front registers and classifies a request (squaring the radii on the
// way), and a two-deep queue decouples it from the back. The back sequencer
// takes a request in idle, then works a start in the slope state or a step
// in the step state; the step that crosses into region two first passes R2A,
// R2B, R2C, R2D and R2E (its start value is built from chained products on
// one shared multiplier). The points then go out through the result register,
// which holds while result_stall is high. The back takes no new request until
// the last result of the previous one has been loaded.

module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS  = mer_pkg::DEF_COORD_BITS,
    parameter int RADIUS_BITS = mer_pkg::DEF_RADIUS_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request channel
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic                       op,
    input  wire logic [COORD_BITS-1:0]      center_x,
    input  wire logic [COORD_BITS-1:0]      center_y,
    input  wire logic [RADIUS_BITS-1:0]     radius_x,
    input  wire logic [RADIUS_BITS-1:0]     radius_y,
    // result channel
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [mer_pkg::OUT_BITS-1:0]    pixel_x,
    output logic [mer_pkg::OUT_BITS-1:0]    pixel_y,
    output logic                            point_valid,
    output logic                            last_of_step,
    output logic                            arc_done
);
    import mer_pkg::*;

    // queued request: kind, centre, vertical radius and both squared radii
    localparam int ENT_W = 1 + 2 * COORD_BITS + 5 * RADIUS_BITS;

    logic             push_valid;
    logic             push_ready;
    logic [ENT_W-1:0] push_data;
    logic             pop_valid;
    logic             pop_take;
    logic [ENT_W-1:0] pop_data;

    // front: accept and classify, square the radii
    mer_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .ENT_W       (ENT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius_x   (radius_x),
        .radius_y   (radius_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short queue so front and back stall independently
    mer_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_take   (pop_take),
        .pop_data   (pop_data)
    );

    // back: midpoint sequencer and result register
    mer_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS),
        .ENT_W       (ENT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_take     (pop_take),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .point_valid  (point_valid),
        .last_of_step (last_of_step),
        .arc_done     (arc_done)
    );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the midpoint ellipse rasterizer
// depends on mer_pkg and midpoint_ellipse_rasterizer; needs no files or arguments
`timescale 1ns / 100ps

module testbench;
    import mer_pkg::*;

    localparam int CB          = DEF_COORD_BITS;
    localparam int RB          = DEF_RADIUS_BITS;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_LEN   = 30;

    // idling schemes, cycled through as requests are accepted
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_phase_t;

    typedef struct {
        cmd_kind_t               kind;
        logic signed [CB-1:0]    cx;
        logic signed [CB-1:0]    cy;
        logic [RB-1:0]           rx;
        logic [RB-1:0]           ry;
    } request_t;

    typedef struct {
        bit [OUT_BITS-1:0] px;
        bit [OUT_BITS-1:0] py;
        bit                has_point;
        bit                last;
        bit                done;
    } point_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                op           = CMD_START;
    logic [CB-1:0]       center_x     = '0;
    logic [CB-1:0]       center_y     = '0;
    logic [RB-1:0]       radius_x     = '0;
    logic [RB-1:0]       radius_y     = '0;
    logic                result_stall = 1'b0;
    logic                item_stall;
    logic                result_valid;
    logic [OUT_BITS-1:0] pixel_x;
    logic [OUT_BITS-1:0] pixel_y;
    logic                point_valid;
    logic                last_of_step;
    logic                arc_done;

    // requests still to be sent and points still owed by the block
    request_t    request_queue[$];
    point_t      expected_points[$];
    request_t    on_bus;
    int          accepted_requests = 0;
    int          quiet_cycles      = 0;
    int          error_count       = 0;
    idle_phase_t idle_phase        = IDLE_NONE;

    idle_phase_t phase_plan[5] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};

    // arc walker state, kept in step with the block
    bit [RB-1:0] ofs_x, ofs_y;
    bit [31:0]   slope_x, slope_y;
    longint      decision;
    longint      rx_sq, ry_sq;
    bit          region_two, arc_busy;
    int          hold_cx, hold_cy;

    midpoint_ellipse_rasterizer #(
        .COORD_BITS  (CB),
        .RADIUS_BITS (RB)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .point_valid  (point_valid),
        .last_of_step (last_of_step),
        .arc_done     (arc_done)
    );

    always #5 clk = ~clk;

    function automatic int sender_idle_pct(idle_phase_t ph);
        case (ph)
            IDLE_SENDER: return 88;
            IDLE_BOTH:   return 16;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(idle_phase_t ph);
        case (ph)
            IDLE_RECEIVER: return 88;
            IDLE_BOTH:     return 16;
            default:       return 0;
        endcase
    endfunction

    // the four mirrored points of the current offset, in the block's order
    function automatic void emit_quad(bit done);
        int dx, dy;
        for (int k = 0; k < 4; k++)
        begin
            dx = (k % 2 == 0) ? int'(ofs_x) : -int'(ofs_x);
            dy = (k < 2) ? int'(ofs_y) : -int'(ofs_y);
            expected_points.push_back('{px: OUT_BITS'(hold_cx + dx),
                                        py: OUT_BITS'(hold_cy + dy),
                                        has_point: 1'b1,
                                        last: (k == 3),
                                        done: (k == 3) && done});
        end
    endfunction

    // advance the arc walker by one accepted request and queue the points it owes
    function automatic void trace_request(request_t r);
        longint odd_x, y_less;
        bit     done;
        if (r.kind == CMD_START)
        begin
            // new arc: any running one is simply dropped
            hold_cx    = r.cx;
            hold_cy    = r.cy;
            rx_sq      = longint'(r.rx) * longint'(r.rx);
            ry_sq      = longint'(r.ry) * longint'(r.ry);
            ofs_x      = '0;
            ofs_y      = r.ry;
            slope_x    = '0;
            slope_y    = 32'(2 * rx_sq * longint'(r.ry));
            // region one start value, held at four times scale
            decision   = 4 * ry_sq - 4 * rx_sq * longint'(r.ry) + rx_sq;
            region_two = 1'b0;
            done       = (ofs_y == 0);
            arc_busy   = !done;
            emit_quad(done);
        end
        else if (!arc_busy)
        begin
            // step with nothing to walk: a lone empty result
            expected_points.push_back('{px: '0, py: '0, has_point: 1'b0,
                                        last: 1'b1, done: 1'b0});
        end
        else
        begin
            // slope has reached -1: rebuild the decision for region two
            if (!region_two && slope_x >= slope_y)
            begin
                odd_x      = 2 * longint'(ofs_x) + 1;
                y_less     = longint'(ofs_y) - 1;
                decision   = ry_sq * odd_x * odd_x + 4 * rx_sq * y_less * y_less
                             - 4 * rx_sq * ry_sq;
                region_two = 1'b1;
            end
            if (!region_two)
            begin
                ofs_x++;
                slope_x += 32'(2 * ry_sq);
                if (decision < 0)
                    decision += 4 * (ry_sq + longint'(slope_x));
                else
                begin
                    ofs_y--;
                    slope_y -= 32'(2 * rx_sq);
                    decision += 4 * (ry_sq + longint'(slope_x) - longint'(slope_y));
                end
            end
            else
            begin
                ofs_y--;
                slope_y -= 32'(2 * rx_sq);
                if (decision > 0)
                    decision += 4 * (rx_sq - longint'(slope_y));
                else
                begin
                    ofs_x++;
                    slope_x += 32'(2 * ry_sq);
                    decision += 4 * (rx_sq - longint'(slope_y) + longint'(slope_x));
                end
            end
            done = (ofs_y == 0);
            if (done)
                arc_busy = 1'b0;
            emit_quad(done);
        end
    endfunction

    function automatic void queue_start(int cx, int cy, int rx, int ry);
        request_queue.push_back('{kind: CMD_START, cx: CB'(cx), cy: CB'(cy),
                                  rx: RB'(rx), ry: RB'(ry)});
    endfunction

    // step requests carry random don't-care fields so every input bit toggles
    function automatic void queue_steps(int n);
        for (int k = 0; k < n; k++)
            request_queue.push_back('{kind: CMD_STEP, cx: CB'($urandom), cy: CB'($urandom),
                                      rx: RB'($urandom), ry: RB'($urandom)});
    endfunction

    // request driver: a new request is offered only once the previous one has gone
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin : drive
            request_t nxt;
            bit       taken;
            taken = item_valid && !item_stall;
            if (taken)
            begin
                trace_request(on_bus);
                accepted_requests++;
                idle_phase <= phase_plan[(accepted_requests / PHASE_LEN) % 5];
            end
            if (!item_valid || taken)
            begin
                if (request_queue.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct(idle_phase))
                begin
                    nxt        = request_queue.pop_front();
                    on_bus     = nxt;
                    item_valid <= 1'b1;
                    op         <= nxt.kind;
                    center_x   <= nxt.cx;
                    center_y   <= nxt.cy;
                    radius_x   <= nxt.rx;
                    radius_y   <= nxt.ry;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: every accepted point against the oldest one owed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin : check
            point_t want;
            if (result_valid && !result_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result: pixel_x %0d pixel_y %0d",
                           $signed(pixel_x), $signed(pixel_y));
                    error_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (pixel_x !== want.px)
                    begin
                        $error("pixel_x: expected %0d, got %0d",
                               $signed(want.px), $signed(pixel_x));
                        error_count++;
                    end
                    if (pixel_y !== want.py)
                    begin
                        $error("pixel_y: expected %0d, got %0d",
                               $signed(want.py), $signed(pixel_y));
                        error_count++;
                    end
                    if (point_valid !== want.has_point)
                    begin
                        $error("point_valid: expected %0d, got %0d", want.has_point, point_valid);
                        error_count++;
                    end
                    if (last_of_step !== want.last)
                    begin
                        $error("last_of_step: expected %0d, got %0d", want.last, last_of_step);
                        error_count++;
                    end
                    if (arc_done !== want.done)
                    begin
                        $error("arc_done: expected %0d, got %0d", want.done, arc_done);
                        error_count++;
                    end
                end
            end
            result_stall <= ($urandom_range(0, 99) < receiver_stall_pct(idle_phase));
        end
    end

    // cycles in which neither channel moves anything
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("testbench: errors");
        $finish;
    end

    initial
    begin : stimulus
        int pick, rx, ry;

        // directed part
        queue_steps(1);                           // step with no arc running
        queue_start(-2048, 2047, 1023, 1023);     // widest centre and radii
        queue_steps(2);
        queue_start(2047, -2048, 3, 0);           // abandons the arc; flat arc ends at once
        queue_steps(1);                           // idle again
        queue_start(0, 0, 0, 3);                  // no width: straight into region two
        queue_steps(4);                           // last one finds the block idle
        queue_start(-1, -1, 2, 1);
        queue_steps(5);
        queue_start(5, -5, 0, 0);                 // single point arc
        queue_start(100, 200, 1023, 1);           // long flat region one
        queue_steps(2);
        queue_start(-300, 40, 1, 1023);           // tall: region two soon
        queue_steps(3);

        // random part, mostly whole arcs with small radii
        while (request_queue.size() < 300)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                rx = $urandom_range(0, 12);
                ry = $urandom_range(0, 12);
                queue_start($urandom, $urandom, rx, ry);
                if (pick < 55)
                    queue_steps(rx + ry + $urandom_range(0, 2));
                else
                    queue_steps($urandom_range(1, rx + ry + 1));  // cut short by the next start
            end
            else if (pick < 80)
            begin
                queue_start($urandom, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023));
                queue_steps($urandom_range(1, 10));
            end
            else if (pick < 90)
            begin
                // narrow and tall, so the region change comes within a few steps
                queue_start($urandom, $urandom, $urandom_range(0, 4), $urandom_range(512, 1023));
                queue_steps($urandom_range(4, 12));
            end
            else
            begin
                queue_steps($urandom_range(1, 3));
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // settle on the falling edge so the driver and monitor have moved on
        do
            @(negedge clk);
        while (request_queue.size() != 0 || item_valid || expected_points.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
